[rtl/spq_pkg.sv]
package spq_pkg;

    localparam int DEPTH  = 16;
    localparam int ID_W   = 16;
    localparam int PRIO_W = 8;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_POP    = 1'b1
    } command_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_HOLD = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } slot_t;

    typedef struct packed {
        logic exec;
    } ctrl_cmd_t;

endpackage

[rtl/spq_if.sv]
interface spq_req_if;
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [spq_pkg::ID_W-1:0]   entry_id;
    logic [spq_pkg::PRIO_W-1:0] entry_priority;

    modport source (output valid, output command, output entry_id,
                    output entry_priority, input ready);
    modport sink   (input valid, input command, input entry_id,
                    input entry_priority, output ready);
endinterface

interface spq_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [spq_pkg::ID_W-1:0]   popped_id;
    logic [spq_pkg::PRIO_W-1:0] popped_priority;
    logic [spq_pkg::STAT_W-1:0] status;
    logic [spq_pkg::OCC_W-1:0]  occupancy;

    modport source (output valid, output popped_id, output popped_priority,
                    output status, output occupancy, input ready);
    modport sink   (input valid, input popped_id, input popped_priority,
                    input status, input occupancy, output ready);
endinterface

[rtl/spq_ctrl.sv]
module spq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output spq_pkg::ctrl_cmd_t cmd
);
    import spq_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        exec;

    // result register frees up in the same cycle it is taken
    assign exec = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (exec)
                    state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (exec)
                    state_next = S_HOLD;
                else if (rsp_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready = 1'b1;
        rsp_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                rsp_valid = 1'b0;
            end
            S_HOLD:
            begin
                req_ready = rsp_ready;
                rsp_valid = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
                rsp_valid = 1'b0;
            end
        endcase
        cmd.exec = exec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/spq_dp.sv]
module spq_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  spq_pkg::ctrl_cmd_t         cmd,
    input  logic                       command,
    input  logic [spq_pkg::ID_W-1:0]   entry_id,
    input  logic [spq_pkg::PRIO_W-1:0] entry_priority,
    output logic [spq_pkg::ID_W-1:0]   popped_id,
    output logic [spq_pkg::PRIO_W-1:0] popped_priority,
    output logic [spq_pkg::STAT_W-1:0] status,
    output logic [spq_pkg::OCC_W-1:0]  occupancy
);
    import spq_pkg::*;

    slot_t             slot_reg [DEPTH];
    slot_t             slot_next [DEPTH];
    logic [DEPTH-1:0]  ge;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  count_dec;
    logic [IDX_W-1:0]  top_idx;
    logic              full;
    logic              empty;
    logic              do_insert;
    logic              do_pop;
    slot_t             res_slot;
    status_t           res_status;
    slot_t             res_slot_reg;
    status_t           res_status_reg;
    logic [CNT_W-1:0]  res_count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign count_dec = count_reg - CNT_W'(1);
    assign top_idx   = count_dec[IDX_W-1:0];
    assign do_insert = cmd.exec && (command == CMD_INSERT) && !full;
    assign do_pop    = cmd.exec && (command == CMD_POP) && !empty;

    // each stored slot compares against the new priority in parallel
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ge[i] = (CNT_W'(i) < count_reg) && (slot_reg[i].prio >= entry_priority);
        end
    end

    // keep at or above new priority, drop new entry at the boundary, shift the rest up
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (ge[i])
                slot_next[i] = slot_reg[i];
            else if (i == 0)
                slot_next[i] = '{id: entry_id, prio: entry_priority};
            else if (ge[(i == 0) ? 0 : i - 1])
                slot_next[i] = '{id: entry_id, prio: entry_priority};
            else
                slot_next[i] = slot_reg[(i == 0) ? 0 : i - 1];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        res_slot   = '0;
        res_status = ST_DONE;
        priority if (command == CMD_INSERT)
        begin
            if (full)
                res_status = ST_OVERFLOW;
            else
                count_next = count_reg + CNT_W'(1);
        end
        else
        begin
            if (empty)
                res_status = ST_UNDERFLOW;
            else
            begin
                count_next = count_dec;
                res_slot   = slot_reg[top_idx];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (do_insert || do_pop)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_slot_reg   <= res_slot;
            res_status_reg <= res_status;
            res_count_reg  <= count_next;
        end
    end

    assign popped_id       = res_slot_reg.id;
    assign popped_priority = res_slot_reg.prio;
    assign status          = res_status_reg;
    assign occupancy       = OCC_W'(res_count_reg);

endmodule

[rtl/sorted_priority_stack.sv]
// sorted priority stack: up to DEPTH (id, priority) entries kept in order,
// highest priority at the bottom, lowest on top
// req channel: one beat per command; command insert places the entry above all
// entries of greater or equal priority, command pop removes the top entry
// rsp channel: exactly one beat per request beat, in order, carrying the
// popped entry (zero on insert or error), status and occupancy after the command
// the response is valid the cycle after the request beat
// throughput: one command per cycle while the receiver takes responses; all
// slots compare against the new priority in parallel and shift together, the
// result register then holds the response
// insert on a full stack returns overflow and changes nothing, pop on an
// empty stack returns underflow with zero fields
// reset empties the stack and drops any pending response; slot contents are
// not cleared
// when the receiver stalls, the response holds and req ready follows rsp
// ready, so at most one response waits
module sorted_priority_stack (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);
    import spq_pkg::*;

    ctrl_cmd_t cmd;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    spq_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .command         (req.command),
        .entry_id        (req.entry_id),
        .entry_priority  (req.entry_priority),
        .popped_id       (rsp.popped_id),
        .popped_priority (rsp.popped_priority),
        .status          (rsp.status),
        .occupancy       (rsp.occupancy)
    );

endmodule

[tb/sv/sorted_priority_stack_tb.sv]
`timescale 1ns / 100ps

module sorted_priority_stack_tb;
    import spq_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int N_ITEMS     = 1250;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 19;
    localparam int CALM_FROM   = 500;
    localparam int CALM_TO     = 850;
    localparam int HOLD_LEN    = 150;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        command_t          cmd;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } stack_cmd_t;

    typedef struct {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        status_t           status;
        logic [OCC_W-1:0]  occ;
    } stack_result_t;

    logic clk;
    logic rst_n;

    spq_req_if req();
    spq_rsp_if rsp();

    sorted_priority_stack u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    stack_cmd_t    cmd_queue[$];
    stack_result_t owed_results[$];
    stack_cmd_t    next_cmd;
    stack_result_t got;
    stack_result_t want;

    // predictor state
    slot_t model_slots [DEPTH];
    int    model_count;

    int cycle_cnt;
    int hold_cnt;
    int hold_events;
    int mismatches;
    int n_stored;
    int n_popped;
    int n_overflow;
    int n_underflow;
    int peak_occ;

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    function automatic stack_result_t apply_command(command_t cmd, logic [ID_W-1:0] id,
                                                    logic [PRIO_W-1:0] prio);
        stack_result_t r;
        int            pos;
        r.id     = '0;
        r.prio   = '0;
        r.status = ST_DONE;
        if (cmd == CMD_INSERT)
        begin
            if (model_count >= DEPTH)
                r.status = ST_OVERFLOW;
            else
            begin
                // lower priorities move up, new entry lands above its equals
                pos = model_count;
                while (pos > 0 && model_slots[pos-1].prio < prio)
                begin
                    model_slots[pos] = model_slots[pos-1];
                    pos--;
                end
                model_slots[pos].id   = id;
                model_slots[pos].prio = prio;
                model_count++;
            end
        end
        else
        begin
            if (model_count == 0)
                r.status = ST_UNDERFLOW;
            else
            begin
                model_count--;
                r.id   = model_slots[model_count].id;
                r.prio = model_slots[model_count].prio;
            end
        end
        r.occ = model_count[OCC_W-1:0];
        return r;
    endfunction

    function automatic void note_mismatch(string field, int exp_val, int act_val);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h",
                     $time, field, exp_val, act_val);
    endfunction

    function automatic void add_cmd(command_t cmd, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
        stack_cmd_t c;
        c.cmd  = cmd;
        c.id   = id;
        c.prio = prio;
        cmd_queue.push_back(c);
    endfunction

    function automatic logic idle_now();
        if (cycle_cnt >= CALM_FROM && cycle_cnt < CALM_TO)
            return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cycle_cnt <= 0;
        else
            cycle_cnt <= cycle_cnt + 1;
    end

    // long receiver hold-offs so the request side backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt    <= 0;
            hold_events <= 0;
        end
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        else if (cycle_cnt == 300 || cycle_cnt == 1100)
        begin
            hold_cnt    <= HOLD_LEN;
            hold_events <= hold_events + 1;
        end
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid          <= 1'b0;
            req.command        <= CMD_INSERT;
            req.entry_id       <= '0;
            req.entry_priority <= '0;
            model_count        = 0;
            n_stored           = 0;
            n_popped           = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                if (req.command == CMD_POP && model_count > 0)
                    n_popped++;
                else if (req.command == CMD_INSERT && model_count < DEPTH)
                    n_stored++;
                owed_results.push_back(apply_command(command_t'(req.command), req.entry_id,
                                                     req.entry_priority));
            end
            if (!req.valid || req.ready)
            begin
                if (cmd_queue.size() != 0 && !idle_now())
                begin
                    next_cmd = cmd_queue.pop_front();
                    req.valid          <= 1'b1;
                    req.command        <= next_cmd.cmd;
                    req.entry_id       <= next_cmd.id;
                    req.entry_priority <= next_cmd.prio;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready   <= 1'b0;
            mismatches  = 0;
            n_overflow  = 0;
            n_underflow = 0;
            peak_occ    = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.id     = rsp.popped_id;
                got.prio   = rsp.popped_priority;
                got.status = status_t'(rsp.status);
                got.occ    = rsp.occupancy;
                if (owed_results.size() == 0)
                    note_mismatch("unexpected beat, status", 0, got.status);
                else
                begin
                    want = owed_results.pop_front();
                    if (got.id !== want.id)
                        note_mismatch("popped_id", want.id, got.id);
                    if (got.prio !== want.prio)
                        note_mismatch("popped_priority", want.prio, got.prio);
                    if (got.status !== want.status)
                        note_mismatch("status", want.status, got.status);
                    if (got.occ !== want.occ)
                        note_mismatch("occupancy", want.occ, got.occ);
                    case (want.status)
                        ST_OVERFLOW:  n_overflow++;
                        ST_UNDERFLOW: n_underflow++;
                        default:
                            if (int'(want.occ) > peak_occ)
                                peak_occ = int'(want.occ);
                    endcase
                end
            end
            if (hold_cnt != 0)
                rsp.ready <= 1'b0;
            else
                rsp.ready <= !idle_now();
        end
    end

    initial
    begin : stimulus
        int total;
        int run_len;
        int mode;
        int ins_pct;
        int narrow;
        command_t c;
        logic [PRIO_W-1:0] p;

        rst_n = 1'b0;

        // directed: empty pop, extremes, ties, fill to full, overflow, pops
        add_cmd(CMD_POP,    16'hA5A5, 8'h5A);
        add_cmd(CMD_INSERT, 16'h0000, 8'd0);
        add_cmd(CMD_INSERT, 16'hFFFF, 8'd255);
        add_cmd(CMD_INSERT, 16'h1234, 8'd100);
        add_cmd(CMD_INSERT, 16'h1235, 8'd100);
        add_cmd(CMD_INSERT, 16'h00FF, 8'd0);
        add_cmd(CMD_POP,    16'hFFFF, 8'hFF);
        for (int i = 0; i < 12; i++)
            add_cmd(CMD_INSERT, 16'h8000 | 16'(i), (i % 3 == 0) ? 8'd255 : 8'(i * 20));
        add_cmd(CMD_INSERT, 16'hDEAD, 8'd128);
        add_cmd(CMD_POP,    16'h0000, 8'h00);
        add_cmd(CMD_POP,    16'h0000, 8'h00);
        add_cmd(CMD_POP,    16'h0000, 8'h00);
        total = cmd_queue.size();

        // random runs biased toward filling, draining or a balanced mix
        while (total < N_ITEMS)
        begin
            run_len = $urandom_range(60, 20);
            mode    = $urandom_range(2);
            ins_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
            narrow  = ($urandom_range(2) == 0);
            for (int i = 0; i < run_len && total < N_ITEMS; i++)
            begin
                c = ($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_POP;
                if (narrow)
                    p = 8'($urandom_range(3));
                else if ($urandom_range(9) == 0)
                    p = $urandom_range(1) ? 8'd255 : 8'd0;
                else
                    p = 8'($urandom);
                add_cmd(c, 16'($urandom), p);
                total++;
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while ((cmd_queue.size() != 0 || req.valid || owed_results.size() != 0)
               && cycle_cnt < CYCLE_LIMIT)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("run stopped at cycle limit with %0d results outstanding",
                     owed_results.size());
            $display("Testbench completed WITH ERRORS");
        end
        else
        begin
            $display("%0d commands checked: %0d stored, %0d popped, %0d overflows, %0d underflows",
                     total, n_stored, n_popped, n_overflow, n_underflow);
            $display("peak occupancy %0d of %0d, %0d receiver hold-offs, %0d mismatches",
                     peak_occ, DEPTH, hold_events, mismatches);
            if (mismatches == 0)
                $display("Testbench completed without errors");
            else
                $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[sorted_priority_stack.f]
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_ctrl.sv
rtl/spq_dp.sv
rtl/sorted_priority_stack.sv
tb/sv/sorted_priority_stack_tb.sv
